[design/scf_eg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCF energy gradient package
// Shared constants, command codes, sequencer types and fixed-point helpers.
// ----------------------------------------------------------------------------
package scf_eg_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_BITS     = 64;
    localparam int OUT_BITS     = 48;
    localparam int IDX_W        = 3;
    localparam int AXIS_W       = 2;
    localparam int CNT_W        = 4;
    localparam int MAX_BASIS    = 8;
    localparam int BASIS_RESET  = 8;
    localparam int DRAIN_CYCLES = 6;
    localparam int DRAIN_W      = 3;
    localparam int MAT_DEPTH    = 64;
    localparam int DER_DEPTH    = 192;
    localparam int TEI_DEPTH    = 12288;
    localparam int NUM_AXES     = 3;

    localparam logic [2:0] CMD_DENSITY = 3'd0;
    localparam logic [2:0] CMD_FOCK    = 3'd1;
    localparam logic [2:0] CMD_CORE    = 3'd2;
    localparam logic [2:0] CMD_OVERLAP = 3'd3;
    localparam logic [2:0] CMD_TWO_E   = 3'd4;
    localparam logic [2:0] CMD_NUCLEAR = 3'd5;
    localparam logic [2:0] CMD_COMPUTE = 3'd6;

    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    typedef logic signed [VALUE_BITS-1:0] t_val;
    typedef logic signed [ACC_BITS-1:0]   t_acc;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_CORE, OP_TE, OP_MAT_A, OP_MAT_B, OP_TRACE,
        OP_FIN_SUB, OP_FIN_NUC, OP_FIN_OUT, OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_MAIN, ST_MAT_A, ST_MAT_B, ST_TRACE, ST_DRAIN,
        ST_FIN_SUB, ST_FIN_NUC, ST_FIN_OUT, ST_EMIT
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [AXIS_W-1:0] axis;
        logic [IDX_W-1:0]  p;
        logic [IDX_W-1:0]  q;
        logic [IDX_W-1:0]  r;
        logic [IDX_W-1:0]  s;
        logic              first;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        t_op                op;
        logic               first;
        logic               last;
        logic [2*IDX_W-1:0] waddr;
    } t_tag;

    localparam t_val VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam t_acc ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    function automatic t_acc sat_acc(input logic [ACC_BITS:0] v);
        if (v[ACC_BITS] != v[ACC_BITS-1]) begin
            return v[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        return v[ACC_BITS-1:0];
    endfunction

    function automatic t_val norm_prod(input logic signed [2*VALUE_BITS:0] v);
        logic signed [2*VALUE_BITS:0] sh;
        sh = v >>> FRAC_BITS;
        if (&sh[2*VALUE_BITS:VALUE_BITS-1] || ~|sh[2*VALUE_BITS:VALUE_BITS-1]) begin
            return sh[VALUE_BITS-1:0];
        end
        return sh[2*VALUE_BITS] ? VAL_MIN : VAL_MAX;
    endfunction

    function automatic t_val sat_val(input t_acc v);
        if (&v[ACC_BITS-1:VALUE_BITS-1] || ~|v[ACC_BITS-1:VALUE_BITS-1]) begin
            return v[VALUE_BITS-1:0];
        end
        return v[ACC_BITS-1] ? VAL_MIN : VAL_MAX;
    endfunction

endpackage

[design/scf_eg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scf_eg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/scf_eg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCF energy gradient controller
// Holds the basis count and walks the contraction loops axis by axis.
// ----------------------------------------------------------------------------
module scf_eg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [3:0]            i_cfg_data,
    input  logic                  i_in_valid,
    input  logic [2:0]            i_in_command,
    input  logic                  i_out_free,
    output logic                  o_in_ready,
    output scf_eg_pkg::t_dp_cmd   o_cmd
);

    scf_eg_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [scf_eg_pkg::CNT_W-1:0]   r_basis;
    logic [scf_eg_pkg::IDX_W-1:0]   r_p, r_q, r_r, r_s, n_p, n_q, n_r, n_s;
    logic                           r_core, n_core;
    logic [scf_eg_pkg::AXIS_W-1:0]  r_axis, n_axis;
    logic [scf_eg_pkg::DRAIN_W-1:0] r_drain, n_drain;
    logic [scf_eg_pkg::CNT_W-1:0]   w_n;
    logic [scf_eg_pkg::IDX_W-1:0]   w_nm1;
    logic                           w_last_p, w_last_q, w_last_r, w_last_s;

    assign w_n = (r_basis > scf_eg_pkg::CNT_W'(scf_eg_pkg::MAX_BASIS)) ?
                 scf_eg_pkg::CNT_W'(scf_eg_pkg::MAX_BASIS) : r_basis;
    assign w_nm1    = scf_eg_pkg::IDX_W'(w_n - 1'b1);
    assign w_last_p = (r_p == w_nm1);
    assign w_last_q = (r_q == w_nm1);
    assign w_last_r = (r_r == w_nm1);
    assign w_last_s = (r_s == w_nm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scf_eg_pkg::ST_IDLE;
            r_ret   <= scf_eg_pkg::ST_IDLE;
            r_basis <= scf_eg_pkg::CNT_W'(scf_eg_pkg::BASIS_RESET);
            r_p     <= '0;
            r_q     <= '0;
            r_r     <= '0;
            r_s     <= '0;
            r_core  <= 1'b0;
            r_axis  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_p     <= n_p;
            r_q     <= n_q;
            r_r     <= n_r;
            r_s     <= n_s;
            r_core  <= n_core;
            r_axis  <= n_axis;
            r_drain <= n_drain;
            if (i_cfg_valid) begin
                r_basis <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_p     = r_p;
        n_q     = r_q;
        n_r     = r_r;
        n_s     = r_s;
        n_core  = r_core;
        n_axis  = r_axis;
        n_drain = r_drain;
        case (r_state)
            scf_eg_pkg::ST_IDLE: begin
                if (i_in_valid && i_in_command == scf_eg_pkg::CMD_COMPUTE) begin
                    n_state = scf_eg_pkg::ST_CLEAR;
                    n_axis  = scf_eg_pkg::AXIS_X;
                end
            end
            scf_eg_pkg::ST_CLEAR: begin
                n_p    = '0;
                n_q    = '0;
                n_r    = '0;
                n_s    = '0;
                n_core = 1'b1;
                n_state = (w_n == '0) ? scf_eg_pkg::ST_FIN_SUB : scf_eg_pkg::ST_MAIN;
            end
            scf_eg_pkg::ST_MAIN: begin
                if (r_core) begin
                    n_core = 1'b0;
                end else if (!w_last_s) begin
                    n_s = r_s + 1'b1;
                end else begin
                    n_s = '0;
                    if (!w_last_r) begin
                        n_r = r_r + 1'b1;
                    end else begin
                        n_r    = '0;
                        n_core = 1'b1;
                        if (!w_last_q) begin
                            n_q = r_q + 1'b1;
                        end else begin
                            n_q = '0;
                            if (!w_last_p) begin
                                n_p = r_p + 1'b1;
                            end else begin
                                n_p     = '0;
                                n_state = scf_eg_pkg::ST_MAT_A;
                            end
                        end
                    end
                end
            end
            scf_eg_pkg::ST_MAT_A, scf_eg_pkg::ST_MAT_B: begin
                if (!w_last_r) begin
                    n_r = r_r + 1'b1;
                end else begin
                    n_r = '0;
                    if (!w_last_q) begin
                        n_q = r_q + 1'b1;
                    end else begin
                        n_q = '0;
                        if (!w_last_p) begin
                            n_p = r_p + 1'b1;
                        end else begin
                            n_p     = '0;
                            n_drain = '0;
                            n_state = scf_eg_pkg::ST_DRAIN;
                            n_ret   = (r_state == scf_eg_pkg::ST_MAT_A) ?
                                      scf_eg_pkg::ST_MAT_B : scf_eg_pkg::ST_TRACE;
                        end
                    end
                end
            end
            scf_eg_pkg::ST_TRACE: begin
                if (!w_last_q) begin
                    n_q = r_q + 1'b1;
                end else begin
                    n_q = '0;
                    if (!w_last_p) begin
                        n_p = r_p + 1'b1;
                    end else begin
                        n_p     = '0;
                        n_drain = '0;
                        n_state = scf_eg_pkg::ST_DRAIN;
                        n_ret   = scf_eg_pkg::ST_FIN_SUB;
                    end
                end
            end
            scf_eg_pkg::ST_DRAIN: begin
                if (r_drain == scf_eg_pkg::DRAIN_W'(scf_eg_pkg::DRAIN_CYCLES - 1)) begin
                    n_state = r_ret;
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end
            scf_eg_pkg::ST_FIN_SUB: begin
                n_state = scf_eg_pkg::ST_FIN_NUC;
            end
            scf_eg_pkg::ST_FIN_NUC: begin
                n_state = scf_eg_pkg::ST_FIN_OUT;
            end
            scf_eg_pkg::ST_FIN_OUT: begin
                if (r_axis == scf_eg_pkg::AXIS_Z) begin
                    n_state = scf_eg_pkg::ST_EMIT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = scf_eg_pkg::ST_CLEAR;
                end
            end
            scf_eg_pkg::ST_EMIT: begin
                if (i_out_free) begin
                    n_state = scf_eg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scf_eg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == scf_eg_pkg::ST_IDLE);
        o_cmd.axis  = r_axis;
        o_cmd.p     = r_p;
        o_cmd.q     = r_q;
        o_cmd.r     = r_r;
        o_cmd.s     = r_s;
        o_cmd.first = (r_r == '0);
        o_cmd.last  = w_last_r;
        case (r_state)
            scf_eg_pkg::ST_CLEAR:   o_cmd.op = scf_eg_pkg::OP_CLEAR;
            scf_eg_pkg::ST_MAIN:    o_cmd.op = r_core ? scf_eg_pkg::OP_CORE : scf_eg_pkg::OP_TE;
            scf_eg_pkg::ST_MAT_A:   o_cmd.op = scf_eg_pkg::OP_MAT_A;
            scf_eg_pkg::ST_MAT_B:   o_cmd.op = scf_eg_pkg::OP_MAT_B;
            scf_eg_pkg::ST_TRACE:   o_cmd.op = scf_eg_pkg::OP_TRACE;
            scf_eg_pkg::ST_FIN_SUB: o_cmd.op = scf_eg_pkg::OP_FIN_SUB;
            scf_eg_pkg::ST_FIN_NUC: o_cmd.op = scf_eg_pkg::OP_FIN_NUC;
            scf_eg_pkg::ST_FIN_OUT: o_cmd.op = scf_eg_pkg::OP_FIN_OUT;
            scf_eg_pkg::ST_EMIT:    o_cmd.op = i_out_free ? scf_eg_pkg::OP_EMIT :
                                                            scf_eg_pkg::OP_NONE;
            default:                o_cmd.op = scf_eg_pkg::OP_NONE;
        endcase
    end

endmodule

[design/scf_eg_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCF energy gradient datapath
// Operand stores, a five-stage multiply and accumulate pipe, and the result.
// ----------------------------------------------------------------------------
module scf_eg_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [2:0]                        i_command,
    input  logic [scf_eg_pkg::IDX_W-1:0]      i_index_p,
    input  logic [scf_eg_pkg::IDX_W-1:0]      i_index_q,
    input  logic [scf_eg_pkg::IDX_W-1:0]      i_index_r,
    input  logic [scf_eg_pkg::IDX_W-1:0]      i_index_s,
    input  logic [scf_eg_pkg::AXIS_W-1:0]     i_axis,
    input  scf_eg_pkg::t_val                  i_load_value,
    input  scf_eg_pkg::t_dp_cmd               i_cmd,
    input  logic                              i_out_ready,
    output logic                              o_out_free,
    output logic                              o_out_valid,
    output logic [scf_eg_pkg::OUT_BITS-1:0]   o_grad_x,
    output logic [scf_eg_pkg::OUT_BITS-1:0]   o_grad_y,
    output logic [scf_eg_pkg::OUT_BITS-1:0]   o_grad_z,
    output logic                              o_saturated
);

    localparam int VB = scf_eg_pkg::VALUE_BITS;
    localparam int AB = scf_eg_pkg::ACC_BITS;
    localparam int OB = scf_eg_pkg::OUT_BITS;

    logic w_ax_ok;
    logic w_we_den, w_we_fock, w_we_core, w_we_ovl, w_we_tei;
    logic [5:0]  w_mat_wa, w_der_wa_lo;
    logic [7:0]  w_der_wa;
    logic [13:0] w_tei_wa;
    logic [5:0]  w_den1_ra, w_den2_ra;
    logic [VB-1:0] w_den1, w_den2, w_fock, w_core, w_ovl, w_tei1, w_tei2, w_amat, w_bmat;
    logic w_we_a, w_we_b;
    scf_eg_pkg::t_val w_dot_val;

    scf_eg_pkg::t_tag r_t1, r_t2, r_t3, r_t4, r_t5;
    scf_eg_pkg::t_val w_x, w_y;
    logic signed [AB-1:0]  w_x64, w_y64;
    logic signed [VB:0]    w_d;
    logic signed [AB-1:0]  r_m1;
    logic signed [VB:0]    r_d2, r_d3;
    scf_eg_pkg::t_val      r_q1, r_q2;
    logic signed [2*VB:0]  w_qa, w_qb, r_m2;
    scf_eg_pkg::t_val      w_te;
    logic signed [AB-1:0]  w_te64, w_q64, r_term;

    scf_eg_pkg::t_acc r_acc, r_tr, r_dot, w_dot, w_nuc64, w_half_tr;
    scf_eg_pkg::t_val r_nuc [scf_eg_pkg::NUM_AXES];
    logic [OB-1:0]    r_grad [scf_eg_pkg::NUM_AXES];
    logic             r_clip, w_fit;
    logic             r_ovalid, r_osat;
    logic [OB-1:0]    r_ox, r_oy, r_oz;

    assign w_ax_ok   = (i_axis != scf_eg_pkg::AXIS_NONE);
    assign w_we_den  = i_load && (i_command == scf_eg_pkg::CMD_DENSITY);
    assign w_we_fock = i_load && (i_command == scf_eg_pkg::CMD_FOCK);
    assign w_we_core = i_load && (i_command == scf_eg_pkg::CMD_CORE) && w_ax_ok;
    assign w_we_ovl  = i_load && (i_command == scf_eg_pkg::CMD_OVERLAP) && w_ax_ok;
    assign w_we_tei  = i_load && (i_command == scf_eg_pkg::CMD_TWO_E) && w_ax_ok;
    assign w_mat_wa    = {i_index_p, i_index_q};
    assign w_der_wa_lo = {i_index_p, i_index_q};
    assign w_der_wa    = {i_axis, w_der_wa_lo};
    assign w_tei_wa    = {i_axis, i_index_p, i_index_r, i_index_q, i_index_s};

    assign w_den1_ra = (i_cmd.op == scf_eg_pkg::OP_MAT_A) ? {i_cmd.p, i_cmd.r} :
                                                            {i_cmd.p, i_cmd.q};
    assign w_den2_ra = (i_cmd.op == scf_eg_pkg::OP_MAT_B) ? {i_cmd.r, i_cmd.q} :
                                                            {i_cmd.s, i_cmd.r};

    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::MAT_DEPTH)) u_den1 (
        .i_clk(i_clk), .i_we(w_we_den), .i_waddr(w_mat_wa), .i_wdata(i_load_value),
        .i_raddr(w_den1_ra), .o_rdata(w_den1));
    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::MAT_DEPTH)) u_den2 (
        .i_clk(i_clk), .i_we(w_we_den), .i_waddr(w_mat_wa), .i_wdata(i_load_value),
        .i_raddr(w_den2_ra), .o_rdata(w_den2));
    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::MAT_DEPTH)) u_fock (
        .i_clk(i_clk), .i_we(w_we_fock), .i_waddr(w_mat_wa), .i_wdata(i_load_value),
        .i_raddr({i_cmd.q, i_cmd.p}), .o_rdata(w_fock));
    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::DER_DEPTH)) u_core (
        .i_clk(i_clk), .i_we(w_we_core), .i_waddr(w_der_wa), .i_wdata(i_load_value),
        .i_raddr({i_cmd.axis, i_cmd.p, i_cmd.q}), .o_rdata(w_core));
    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::DER_DEPTH)) u_ovl (
        .i_clk(i_clk), .i_we(w_we_ovl), .i_waddr(w_der_wa), .i_wdata(i_load_value),
        .i_raddr({i_cmd.axis, i_cmd.r, i_cmd.q}), .o_rdata(w_ovl));
    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::TEI_DEPTH)) u_tei1 (
        .i_clk(i_clk), .i_we(w_we_tei), .i_waddr(w_tei_wa), .i_wdata(i_load_value),
        .i_raddr({i_cmd.axis, i_cmd.p, i_cmd.r, i_cmd.q, i_cmd.s}), .o_rdata(w_tei1));
    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::TEI_DEPTH)) u_tei2 (
        .i_clk(i_clk), .i_we(w_we_tei), .i_waddr(w_tei_wa), .i_wdata(i_load_value),
        .i_raddr({i_cmd.axis, i_cmd.p, i_cmd.r, i_cmd.s, i_cmd.q}), .o_rdata(w_tei2));
    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::MAT_DEPTH)) u_amat (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(r_t5.waddr), .i_wdata(w_dot_val),
        .i_raddr({i_cmd.p, i_cmd.r}), .o_rdata(w_amat));
    scf_eg_ram #(.WIDTH(VB), .DEPTH(scf_eg_pkg::MAT_DEPTH)) u_bmat (
        .i_clk(i_clk), .i_we(w_we_b), .i_waddr(r_t5.waddr), .i_wdata(w_dot_val),
        .i_raddr({i_cmd.p, i_cmd.q}), .o_rdata(w_bmat));

    always_comb begin
        case (r_t1.op)
            scf_eg_pkg::OP_CORE:  begin w_x = w_den1; w_y = w_core; end
            scf_eg_pkg::OP_TE:    begin w_x = w_den1; w_y = w_den2; end
            scf_eg_pkg::OP_MAT_A: begin w_x = w_den1; w_y = w_ovl;  end
            scf_eg_pkg::OP_MAT_B: begin w_x = w_amat; w_y = w_den2; end
            scf_eg_pkg::OP_TRACE: begin w_x = w_bmat; w_y = w_fock; end
            default:              begin w_x = '0;     w_y = '0;     end
        endcase
    end

    assign w_x64  = w_x;
    assign w_y64  = w_y;
    assign w_d    = {w_tei1[VB-1], w_tei1} - {{2{w_tei2[VB-1]}}, w_tei2[VB-1:1]};
    assign w_qa   = r_q1;
    assign w_qb   = r_d3;
    assign w_te   = scf_eg_pkg::norm_prod(r_m2);
    assign w_te64 = w_te;
    assign w_q64  = r_q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.op <= scf_eg_pkg::OP_NONE;
            r_t2.op <= scf_eg_pkg::OP_NONE;
            r_t3.op <= scf_eg_pkg::OP_NONE;
            r_t4.op <= scf_eg_pkg::OP_NONE;
            r_t5.op <= scf_eg_pkg::OP_NONE;
        end else begin
            r_t1.op <= i_cmd.op;
            r_t2.op <= r_t1.op;
            r_t3.op <= r_t2.op;
            r_t4.op <= r_t3.op;
            r_t5.op <= r_t4.op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1.first <= i_cmd.first;
        r_t1.last  <= i_cmd.last;
        r_t1.waddr <= {i_cmd.p, i_cmd.q};
        {r_t2.first, r_t2.last, r_t2.waddr} <= {r_t1.first, r_t1.last, r_t1.waddr};
        {r_t3.first, r_t3.last, r_t3.waddr} <= {r_t2.first, r_t2.last, r_t2.waddr};
        {r_t4.first, r_t4.last, r_t4.waddr} <= {r_t3.first, r_t3.last, r_t3.waddr};
        {r_t5.first, r_t5.last, r_t5.waddr} <= {r_t4.first, r_t4.last, r_t4.waddr};
        r_m1   <= w_x64 * w_y64;
        r_d2   <= w_d;
        r_q1   <= scf_eg_pkg::norm_prod({r_m1[AB-1], r_m1});
        r_d3   <= r_d2;
        r_m2   <= w_qa * w_qb;
        r_q2   <= r_q1;
        r_term <= (r_t4.op == scf_eg_pkg::OP_TE) ? (w_te64 >>> 1) : w_q64;
    end

    assign w_dot     = r_t5.first ? r_term :
                       scf_eg_pkg::sat_acc({r_dot[AB-1], r_dot} + {r_term[AB-1], r_term});
    assign w_dot_val = scf_eg_pkg::sat_val(w_dot);
    assign w_we_a    = (r_t5.op == scf_eg_pkg::OP_MAT_A) && r_t5.last;
    assign w_we_b    = (r_t5.op == scf_eg_pkg::OP_MAT_B) && r_t5.last;
    assign w_nuc64   = r_nuc[i_cmd.axis];
    assign w_half_tr = r_tr >>> 1;
    assign w_fit     = &r_acc[AB-1:OB-1] || ~|r_acc[AB-1:OB-1];

    always_ff @(posedge i_clk) begin
        if (i_load && i_command == scf_eg_pkg::CMD_NUCLEAR && w_ax_ok) begin
            r_nuc[i_axis] <= i_load_value;
        end
        case (r_t5.op)
            scf_eg_pkg::OP_CORE, scf_eg_pkg::OP_TE: begin
                r_acc <= scf_eg_pkg::sat_acc({r_acc[AB-1], r_acc} + {r_term[AB-1], r_term});
            end
            scf_eg_pkg::OP_TRACE: begin
                r_tr <= scf_eg_pkg::sat_acc({r_tr[AB-1], r_tr} + {r_term[AB-1], r_term});
            end
            scf_eg_pkg::OP_MAT_A, scf_eg_pkg::OP_MAT_B: begin
                r_dot <= w_dot;
            end
            default: begin
            end
        endcase
        case (i_cmd.op)
            scf_eg_pkg::OP_CLEAR: begin
                r_acc <= '0;
                r_tr  <= '0;
            end
            scf_eg_pkg::OP_FIN_SUB: begin
                r_acc <= scf_eg_pkg::sat_acc({r_acc[AB-1], r_acc} -
                                             {w_half_tr[AB-1], w_half_tr});
            end
            scf_eg_pkg::OP_FIN_NUC: begin
                r_acc <= scf_eg_pkg::sat_acc({r_acc[AB-1], r_acc} +
                                             {w_nuc64[AB-1], w_nuc64});
            end
            scf_eg_pkg::OP_FIN_OUT: begin
                if (w_fit) begin
                    r_grad[i_cmd.axis] <= r_acc[OB-1:0];
                end else begin
                    r_grad[i_cmd.axis] <= {r_acc[AB-1], {(OB-1){~r_acc[AB-1]}}};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_clip   <= 1'b0;
        end else begin
            if (i_cmd.op == scf_eg_pkg::OP_CLEAR && i_cmd.axis == scf_eg_pkg::AXIS_X) begin
                r_clip <= 1'b0;
            end else if (i_cmd.op == scf_eg_pkg::OP_FIN_OUT && !w_fit) begin
                r_clip <= 1'b1;
            end
            if (i_cmd.op == scf_eg_pkg::OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == scf_eg_pkg::OP_EMIT) begin
            r_ox   <= r_grad[0];
            r_oy   <= r_grad[1];
            r_oz   <= r_grad[2];
            r_osat <= r_clip;
        end
    end

    assign o_out_free  = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_grad_x    = r_ox;
    assign o_grad_y    = r_oy;
    assign o_grad_z    = r_oz;
    assign o_saturated = r_osat;

endmodule

[design/scf_energy_gradient_contraction.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCF energy gradient contraction, top level
// A load beat is accepted while the input is open. A compute beat closes the
// input after its accept until its result is handed to the output register,
// while the single multiply and accumulate pipe reads one term per cycle as it
// walks the loops. The result is presented in the cycle after that hand-over,
// and a result still waiting at the output delays the hand-over.
// Reset is synchronous and active low; it clears control state and sets the
// basis count to eight, while the stores keep their contents.
// ----------------------------------------------------------------------------
module scf_energy_gradient_contraction (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // index_p[2:0], index_q[5:3], index_r[8:6], index_s[11:9], axis[13:12],
    // load_value[45:14], zero padding[47:46]
    input  logic [47:0]  i_s_tdata,
    // command[2:0]
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // grad_x[47:0], grad_y[95:48], grad_z[143:96]
    output logic [143:0] o_m_tdata,
    // saturated[0]
    output logic         o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_data
);

    scf_eg_pkg::t_dp_cmd w_cmd;
    logic                w_out_free;
    logic                w_load;

    assign o_cfg_ready = 1'b1;
    assign w_load      = i_s_tvalid && o_s_tready;

    scf_eg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_s_tvalid),
        .i_in_command (i_s_tuser),
        .i_out_free   (w_out_free),
        .o_in_ready   (o_s_tready),
        .o_cmd        (w_cmd)
    );

    scf_eg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_command    (i_s_tuser),
        .i_index_p    (i_s_tdata[2:0]),
        .i_index_q    (i_s_tdata[5:3]),
        .i_index_r    (i_s_tdata[8:6]),
        .i_index_s    (i_s_tdata[11:9]),
        .i_axis       (i_s_tdata[13:12]),
        .i_load_value (i_s_tdata[45:14]),
        .i_cmd        (w_cmd),
        .i_out_ready  (i_m_tready),
        .o_out_free   (w_out_free),
        .o_out_valid  (o_m_tvalid),
        .o_grad_x     (o_m_tdata[47:0]),
        .o_grad_y     (o_m_tdata[95:48]),
        .o_grad_z     (o_m_tdata[143:96]),
        .o_saturated  (o_m_tuser)
    );

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == scf_eg_pkg::CMD_COMPUTE) |=> !o_s_tready)
        else $error("input accepted right after a compute beat");

    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op != scf_eg_pkg::OP_NONE) |-> !o_s_tready)
        else $error("datapath command issued while accepting input");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == scf_eg_pkg::OP_EMIT) |-> (!o_m_tvalid || i_m_tready))
        else $error("result emitted over a pending result");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == scf_eg_pkg::OP_EMIT) |=> o_m_tvalid)
        else $error("emitted result not presented");

endmodule
